/* sv/abkf_pkg.sv */
// ----------------------------------------------------------------------------
// abkf_pkg
// Shared types, widths and register codes of the angle/bias Kalman filter.
// ----------------------------------------------------------------------------
package abkf_pkg;

    localparam int ANG_W = 32;
    localparam int COV_W = 48;
    localparam int CFG_W = 32;

    localparam logic [31:0] RST_QA   = 32'd4294967;
    localparam logic [31:0] RST_QB   = 32'd12884902;
    localparam logic [31:0] RST_R    = 32'd8388608;
    localparam logic [31:0] RST_DT   = 32'd21474836;

    typedef enum logic [1:0]
    {
        REG_QA = 2'd0,
        REG_QB = 2'd1,
        REG_R  = 2'd2,
        REG_DT = 2'd3
    } reg_idx_t;

    // request/response between sequencer and the serial arithmetic unit
    typedef struct packed
    {
        logic        start;
        logic        is_div;
        logic [63:0] a;
        logic [63:0] b;
    } op_req_t;

    typedef struct packed
    {
        logic        done;
        logic [63:0] q;
        logic        hi_nz;
        logic        lo_nz;
    } op_rsp_t;

    // saturate a 66-bit signed value to w bits (w <= 48)
    function automatic logic signed [65:0] sat66(input logic signed [65:0] x, input int w);
        logic signed [65:0] lim;
        lim = 66'sd1 <<< (w - 1);
        if (x > lim - 66'sd1)
            return lim - 66'sd1;
        if (x < -lim)
            return -lim;
        return x;
    endfunction

endpackage

/* sv/angle_bias_kalman_filter_core.sv */
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter_core
// Two-state tilt Kalman filter with a shared bit-serial mul/div unit.
// ----------------------------------------------------------------------------
// Sequence: 13 serial operations, each issued to the shared unit and waited on,
// before the result shows; 9 operations when the innovation variance is not
// positive.
// Throughput: one item at a time; the next input is taken once the result is taken.
// Reset: asynchronous, clears bias and covariance, loads register defaults.
module angle_bias_kalman_filter_core
    import abkf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // prior_angle, gyro_rate, measured_angle
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // angle_estimate
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [3:0]
    {
        ST_IDLE = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_OUT = 4'b1000
    } state_t;

    typedef logic signed [65:0] w_t;

    state_t state_reg, state_next;
    logic [4:0] op_reg, op_next;
    logic [31:0] qa_cfg_reg, qb_cfg_reg, r_cfg_reg, dt_cfg_reg;
    logic signed [31:0] bias_reg, prior_reg, rate_reg, meas_reg, ang_reg, innov_reg, out_reg;
    logic signed [47:0] c00_reg, c01_reg, c10_reg, c11_reg;
    logic signed [47:0] p00_reg, p01_reg, p10_reg, p11_reg, k0_reg, k1_reg;
    logic signed [49:0] s_reg;
    logic [47:0] qa_reg;
    logic  neg_reg;
    logic  sign_p_reg;
    op_req_t req;
    op_rsp_t rsp;
    logic signed [31:0] d_val;
    logic signed [47:0] mul_res;
    logic [63:0] dq;
    logic        div_big;
    logic signed [47:0] div_res;

    abkf_serial_unit u_unit (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    assign pready = 1'b1;
    always_comb
    begin
        case (paddr[3:2])
            REG_QA:  prdata = qa_cfg_reg;
            REG_QB:  prdata = qb_cfg_reg;
            REG_R:   prdata = r_cfg_reg;
            default: prdata = dt_cfg_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qa_cfg_reg <= RST_QA;
            qb_cfg_reg <= RST_QB;
            r_cfg_reg  <= RST_R;
            dt_cfg_reg <= RST_DT;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_QA:  qa_cfg_reg <= pwdata;
                REG_QB:  qb_cfg_reg <= pwdata;
                REG_R:   r_cfg_reg  <= pwdata;
                default: dt_cfg_reg <= pwdata;
            endcase
        end
    end

    assign d_val = 32'(sat66(w_t'(rate_reg) - w_t'(bias_reg), 32));

    // operand pair and sign for each serial operation
    function automatic logic [63:0] mg(input logic signed [47:0] x);
        return x[47] ? 64'(-{{16{x[47]}}, x}) : 64'({16'd0, x});
    endfunction

    always_comb
    begin
        req.a = 64'd0;
        req.b = 64'd0;
        req.is_div = 1'b0;
        case (op_reg)
            // noise terms: pre-shift by 8 so the Q32 product gives (q * dt) >> 24
            5'd0:  begin req.a = {24'd0, qa_cfg_reg, 8'd0}; req.b = {32'd0, dt_cfg_reg}; end
            5'd1:  begin req.a = {24'd0, qb_cfg_reg, 8'd0}; req.b = {32'd0, dt_cfg_reg}; end
            5'd2:  begin req.a = mg(48'(d_val)); req.b = {32'd0, dt_cfg_reg}; end
            5'd3:  begin
                       req.a = mg(48'(sat66(w_t'(c10_reg) + w_t'(c01_reg), 48)));
                       req.b = {32'd0, dt_cfg_reg};
                   end
            5'd4:  begin req.a = mg(c11_reg); req.b = {32'd0, dt_cfg_reg}; end
            5'd5:  begin req.a = mg(p00_reg); req.b = 64'(s_reg); req.is_div = 1'b1; end
            5'd6:  begin req.a = mg(p10_reg); req.b = 64'(s_reg); req.is_div = 1'b1; end
            5'd7:  begin req.a = mg(k1_reg); req.b = mg(48'(innov_reg)); end
            5'd8:  begin req.a = mg(k0_reg); req.b = mg(48'(innov_reg)); end
            5'd9:  begin req.a = mg(k0_reg); req.b = mg(p00_reg); end
            5'd10: begin req.a = mg(k0_reg); req.b = mg(p01_reg); end
            5'd11: begin req.a = mg(k1_reg); req.b = mg(p00_reg); end
            default: begin req.a = mg(k1_reg); req.b = mg(p01_reg); end
        endcase
        req.start = (state_reg == ST_ISSUE);
    end

    // signed, floored, saturated Q32 product from the serial magnitude result
    always_comb
    begin
        logic [64:0] q1;
        q1 = {1'b0, rsp.q} + ((neg_reg && rsp.lo_nz) ? 65'd1 : 65'd0);
        if (neg_reg)
            mul_res = (rsp.hi_nz || q1 > 65'h8000_0000_0000) ? 48'sh8000_0000_0000
                      : 48'(-q1[47:0]);
        else
            mul_res = (rsp.hi_nz || rsp.q > 64'h7FFF_FFFF_FFFF) ? 48'sh7FFF_FFFF_FFFF
                      : 48'(rsp.q);
        // integer quotient of 2^15 or more saturates the gain
        div_big = mg(op_reg == 5'd5 ? p00_reg : p10_reg) >= (64'(s_reg) << 15);
        // quotient of up<<32 / s, saturated magnitude
        dq = (div_big || rsp.q > 64'h7FFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF : rsp.q;
        div_res = sign_p_reg ? 48'(-dq[47:0]) : 48'(dq[47:0]);
    end

    // sign of each op: product sign or dividend sign
    logic neg_calc;
    always_comb
    begin
        case (op_reg)
            5'd0, 5'd1: neg_calc = 1'b0;
            5'd2:  neg_calc = d_val[31];
            5'd3:  neg_calc = sat66(w_t'(c10_reg) + w_t'(c01_reg), 48) < 0;
            5'd4:  neg_calc = c11_reg[47];
            5'd5:  neg_calc = p00_reg[47];
            5'd6:  neg_calc = p10_reg[47];
            5'd7:  neg_calc = k1_reg[47] ^ innov_reg[31];
            5'd8:  neg_calc = k0_reg[47] ^ innov_reg[31];
            5'd9:  neg_calc = k0_reg[47] ^ p00_reg[47];
            5'd10: neg_calc = k0_reg[47] ^ p01_reg[47];
            5'd11: neg_calc = k1_reg[47] ^ p00_reg[47];
            default: neg_calc = k1_reg[47] ^ p01_reg[47];
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) begin state_next = ST_ISSUE; op_next = 5'd0; end
            ST_ISSUE: state_next = ST_WAIT;
            ST_WAIT:
                if (rsp.done)
                begin
                    if (op_reg == 5'd12)
                        state_next = ST_OUT;
                    else if (op_reg == 5'd4 && s_reg <= 0)
                    begin
                        op_next = 5'd9;
                        state_next = ST_ISSUE;
                    end
                    else
                    begin
                        op_next = op_reg + 5'd1;
                        state_next = ST_ISSUE;
                    end
                end
            ST_OUT:   if (m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg <= 5'd0;
            bias_reg <= '0;
            c00_reg <= '0;
            c01_reg <= '0;
            c10_reg <= '0;
            c11_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
            if (state_reg == ST_WAIT && rsp.done)
            begin
                case (op_reg)
                    5'd7: bias_reg <= 32'(sat66(w_t'(bias_reg) + w_t'(mul_res), 32));
                    5'd9: c00_reg <= 48'(sat66(w_t'(p00_reg) - w_t'(mul_res), 48));
                    5'd10: c01_reg <= 48'(sat66(w_t'(p01_reg) - w_t'(mul_res), 48));
                    5'd11: c10_reg <= 48'(sat66(w_t'(p10_reg) - w_t'(mul_res), 48));
                    5'd12: c11_reg <= 48'(sat66(w_t'(p11_reg) - w_t'(mul_res), 48));
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_tvalid)
        begin
            prior_reg <= s_tdata[31:0];
            rate_reg <= s_tdata[63:32];
            meas_reg <= s_tdata[95:64];
            k0_reg <= '0;
            k1_reg <= '0;
        end
        if (state_reg == ST_ISSUE)
        begin
            neg_reg <= neg_calc;
            sign_p_reg <= neg_calc;
        end
        if (state_reg == ST_WAIT && rsp.done)
        begin
            case (op_reg)
                5'd0: qa_reg <= 48'(rsp.q);
                5'd1: p11_reg <= 48'(sat66(w_t'(c11_reg) + w_t'({2'd0, rsp.q}), 48));
                5'd2: ang_reg <= 32'(sat66(w_t'(prior_reg) + w_t'(mul_res), 32));
                5'd3: p00_reg <= 48'(sat66(w_t'(c00_reg) - w_t'(mul_res)
                                 + w_t'({18'd0, qa_reg}), 48));
                5'd4:
                begin
                    p01_reg <= 48'(sat66(w_t'(c01_reg) - w_t'(mul_res), 48));
                    p10_reg <= 48'(sat66(w_t'(c10_reg) - w_t'(mul_res), 48));
                    innov_reg <= 32'(sat66(w_t'(meas_reg) - w_t'(ang_reg), 32));
                    out_reg <= ang_reg;
                end
                5'd5: k0_reg <= div_res;
                5'd6: k1_reg <= div_res;
                5'd8: out_reg <= 32'(sat66(w_t'(ang_reg) + w_t'(mul_res), 32));
                default: ;
            endcase
        end
        // innovation variance, valid once p00 is known
        if (state_reg == ST_WAIT && rsp.done && op_reg == 5'd3)
            s_reg <= 50'(sat66(w_t'(c00_reg) - w_t'(mul_res) + w_t'({18'd0, qa_reg}), 48)
                     + w_t'({r_cfg_reg, 16'd0}));
    end

endmodule

/* sv/abkf_serial_unit.sv */
// ----------------------------------------------------------------------------
// abkf_serial_unit
// Bit-serial unsigned multiplier (64x64 shift-add) and restoring divider,
// one bit per cycle while an operation runs. The divider returns
// (a << 32) / b and needs a >> 32 below b.
// ----------------------------------------------------------------------------
module abkf_serial_unit
    import abkf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  op_req_t req,
    output op_rsp_t rsp
);

    logic         busy_reg, busy_next;
    logic         div_reg, div_next;
    logic [5:0]   cnt_reg, cnt_next;
    logic [127:0] acc_reg, acc_next;
    logic [63:0]  b_reg, b_next;
    logic         done_reg, done_next;
    logic [64:0]  trial;
    logic [64:0]  psum;

    always_comb
    begin
        busy_next = busy_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        b_next    = b_reg;
        done_next = 1'b0;
        trial     = {1'b0, acc_reg[126:63]} - {1'b0, b_reg};
        psum      = {1'b0, acc_reg[127:64]} + (acc_reg[0] ? {1'b0, b_reg} : 65'd0);
        if (req.start)
        begin
            busy_next = 1'b1;
            div_next  = req.is_div;
            cnt_next  = 6'd0;
            b_next    = req.b;
            // divide: a >> 32 preloads the remainder, a << 32 is shifted in
            if (req.is_div)
                acc_next = {32'd0, req.a, 32'd0};
            else
                acc_next = {64'd0, req.a};
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                // restoring step: remainder in [127:64], quotient shifts in low
                if (!trial[64])
                    acc_next = {trial[63:0], acc_reg[62:0], 1'b1};
                else
                    acc_next = {acc_reg[126:0], 1'b0};
            end
            else
            begin
                // shift-add step, multiplier bits consumed from the bottom
                acc_next = {psum, acc_reg[63:1]};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        acc_reg <= acc_next;
        b_reg   <= b_next;
    end

    // multiply: q = product >> 32, flags on top/bottom; divide: q = quotient
    assign rsp.done  = done_reg;
    assign rsp.q     = div_reg ? acc_reg[63:0] : acc_reg[95:32];
    assign rsp.hi_nz = div_reg ? 1'b0 : (acc_reg[127:96] != 32'd0);
    assign rsp.lo_nz = div_reg ? 1'b0 : (acc_reg[31:0] != 32'd0);

endmodule

/* sv/abkf_checker.sv */
// ----------------------------------------------------------------------------
// abkf_checker
// Port-level checks of the filter core, bound to the top level.
// ----------------------------------------------------------------------------
module abkf_checker
(
    input logic clk,
    input logic rst_n,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [31:0] m_tdata,
    input logic pready
);

    // one item in flight: no input taken while a result is shown
    a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    // result holds while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped under stall");

    // accepted input cannot yield a result in the next cycle
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !m_tvalid)
        else $error("result too early");

    a_rdy: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind angle_bias_kalman_filter_core abkf_checker u_chk (.*);

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the angle/bias Kalman filter core. A bit-exact
// fixed-point filter model runs next to the block on every accepted input
// transaction. Each output transaction is checked against the oldest queued
// estimate. The stimulus covers field extremes, zero time step and zero
// measurement noise, register extremes, tracking runs with random noise
// settings, and a long output hold-off.
// ----------------------------------------------------------------------------
module testbench
    import abkf_pkg::*;
();

    localparam int HOLD_CYCLES = 3000;
    localparam int IDLE_LIMIT  = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;    // prior_angle, gyro_rate, measured_angle
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // angle_estimate
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    angle_bias_kalman_filter_core u_dut (.*);

    always #5 clk = ~clk;

    // filter model: registers and state
    logic [31:0] noise_angle, noise_bias, noise_meas, step_dt;
    longint      bias_est, p_aa, p_ab, p_ba, p_bb;
    logic [31:0] last_est;

    logic [31:0] est_queue[$];
    int          errors = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    bit          no_idle = 1'b0;
    bit          hold_req = 1'b0;
    int          idle_cycles = 0;

    function automatic longint sat_w(logic signed [127:0] x, int w);
        logic signed [127:0] lim;
        lim = 128'sd1 <<< (w - 1);
        if (x > lim - 1)
            return longint'(lim - 1);
        if (x < -lim)
            return longint'(-lim);
        return longint'(x);
    endfunction

    // floor(a*b / 2^32), saturated
    function automatic longint mul_q32(longint a, longint b, int w);
        logic signed [127:0] pa, pb, prod;
        pa = a;
        pb = b;
        prod = pa * pb;
        return sat_w(prod >>> 32, w);
    endfunction

    // gain p/s in Q16.32, truncated toward zero, magnitude saturated
    function automatic longint gain_q32(longint p, longint s);
        logic [127:0] up, us, q, maxm;
        up = (p < 0) ? -p : p;
        us = s;
        maxm = (128'd1 << 47) - 1;
        q = up / us;
        if (q >= (128'd1 << 15))
            q = maxm;
        else
            q = (up << 32) / us;
        if (q > maxm)
            q = maxm;
        return (p < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint sx32(logic [31:0] v);
        return longint'($signed(v));
    endfunction

    // one filter step; updates state, returns the corrected angle
    function automatic logic [31:0] kalman_step(logic [31:0] prior_angle,
                                                logic [31:0] gyro_rate,
                                                logic [31:0] measured_angle);
        longint dt, qa, qb, d, ang, p00, p01, p10, p11, s, k0, k1, innov;
        logic [63:0] qa_u, qb_u;
        dt = longint'(step_dt);
        qa_u = 64'(noise_angle) * 64'(step_dt);
        qb_u = 64'(noise_bias) * 64'(step_dt);
        qa = longint'(qa_u >> 24);
        qb = longint'(qb_u >> 24);
        k0 = 0;
        k1 = 0;
        // predict
        d   = sat_w(sx32(gyro_rate) - bias_est, 32);
        ang = sat_w(sx32(prior_angle) + mul_q32(d, dt, 48), 32);
        p00 = sat_w(p_aa - mul_q32(sat_w(p_ba + p_ab, 48), dt, 48) + qa, 48);
        p01 = sat_w(p_ab - mul_q32(p_bb, dt, 48), 48);
        p10 = sat_w(p_ba - mul_q32(p_bb, dt, 48), 48);
        p11 = sat_w(p_bb + qb, 48);
        // gains; a non-positive innovation variance leaves them at zero
        s = p00 + (longint'(noise_meas) <<< 16);
        if (s > 0)
        begin
            k0 = gain_q32(p00, s);
            k1 = gain_q32(p10, s);
        end
        // correct, using the predicted p00 and p01
        innov    = sat_w(sx32(measured_angle) - ang, 32);
        bias_est = sat_w(bias_est + mul_q32(k1, innov, 48), 32);
        ang      = sat_w(ang + mul_q32(k0, innov, 48), 32);
        p_aa     = sat_w(p00 - mul_q32(k0, p00, 48), 48);
        p_ab     = sat_w(p01 - mul_q32(k0, p01, 48), 48);
        p_ba     = sat_w(p10 - mul_q32(k1, p00, 48), 48);
        p_bb     = sat_w(p11 - mul_q32(k1, p01, 48), 48);
        return ang[31:0];
    endfunction

    // ------------------------------------------------------------------
    // shared drivers
    // ------------------------------------------------------------------
    task automatic send_sample(logic [31:0] prior_angle, logic [31:0] gyro_rate,
                               logic [31:0] measured_angle);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {measured_angle, gyro_rate, prior_angle};
        do
            @(posedge clk);
        while (!s_tready);
        last_est = kalman_step(prior_angle, gyro_rate, measured_angle);
        est_queue.push_back(last_est);
        items_sent++;
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(idx) << 2;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_QA:  noise_angle = value;
            REG_QB:  noise_bias  = value;
            REG_R:   noise_meas  = value;
            REG_DT:  step_dt     = value;
            default: ;
        endcase
    endtask

    // registers are to be written only while idle; the block does not enforce it
    task automatic drain();
        s_tvalid <= 1'b0;
        while (est_queue.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_noise(logic [31:0] qa, logic [31:0] qb, logic [31:0] r,
                             logic [31:0] dt);
        drain();
        write_reg(REG_QA, qa);
        write_reg(REG_QB, qb);
        write_reg(REG_R, r);
        write_reg(REG_DT, dt);
    endtask

    // well-formed tilt sample: previous estimate fed back, small rate and error
    task automatic send_tracking();
        logic [31:0] rate, meas;
        rate = 32'($signed($urandom_range(0, 400 << 16)) - (200 << 16));
        meas = last_est + 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
        send_sample(last_est, rate, meas);
    endtask

    // ------------------------------------------------------------------
    // output checker with random stalls and one long hold-off
    // ------------------------------------------------------------------
    initial
    begin
        int stall;
        logic [31:0] want;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = no_idle ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            results_seen++;
            if (est_queue.size() == 0)
            begin
                $error("angle_estimate: unexpected transaction, actual %h", m_tdata);
                errors++;
            end
            else
            begin
                want = est_queue.pop_front();
                if (m_tdata !== want)
                begin
                    $error("angle_estimate: expected %h, actual %h", want, m_tdata);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_field_extremes();
        logic [31:0] edges[4];
        edges = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};
        for (int i = 0; i < 4; i++)
            send_sample(edges[i], edges[(i + 1) % 4], edges[(i + 2) % 4]);
        send_sample(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        send_sample(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
        for (int i = 0; i < 6; i++)
            send_tracking();
    endtask

    task automatic test_zero_step_and_noise();
        // zero time step: prediction holds angle and covariance
        set_noise(32'd4294967, 32'd12884902, 32'd8388608, 32'd0);
        for (int i = 0; i < 3; i++)
            send_tracking();
        // zero measurement noise: the first sample clears the angle variance,
        // the second then sees no innovation variance
        set_noise(32'd0, 32'd0, 32'd0, 32'd0);
        send_sample(32'h0001_0000, 32'h0002_0000, 32'h0010_0000);
        send_sample(32'h0001_0000, 32'h0002_0000, 32'h0010_0000);
        set_noise(32'd0, 32'd0, 32'd0, 32'd21474836);
        for (int i = 0; i < 3; i++)
            send_tracking();
        // register maxima and minima
        set_noise(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_sample(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        send_tracking();
        set_noise(32'd0, 32'd0, 32'd1, 32'd1);
        send_tracking();
        send_sample(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase == 0)
                set_noise(RST_QA, RST_QB, RST_R, RST_DT);
            else
                set_noise($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 26),
                          $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 26),
                          $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 1 << 28),
                          $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 1 << 28));
            no_idle = (phase == 3);
            for (int i = 0; i < 196; i++)
            begin
                if ($urandom_range(0, 99) < 15)
                    send_sample($urandom, $urandom, $urandom);
                else
                    send_tracking();
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic test_output_hold();
        hold_req = 1'b1;
        for (int i = 0; i < 60; i++)
            send_tracking();
    endtask

    initial
    begin
        noise_angle = RST_QA;
        noise_bias  = RST_QB;
        noise_meas  = RST_R;
        step_dt     = RST_DT;
        bias_est = 0;
        p_aa = 0;
        p_ab = 0;
        p_ba = 0;
        p_bb = 0;
        last_est = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_zero_step_and_noise();
        test_random_settings();
        test_output_hold();

        drain();
        repeat (100) @(posedge clk);
        $display("Sent %0d samples, checked %0d estimates under the reset registers",
                 items_sent, results_seen);
        $display("and 13 written settings: zero step, zero noise, extremes, long hold-off.");
        if (errors == 0 && est_queue.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* files.f */
sv/abkf_pkg.sv
sv/abkf_serial_unit.sv
sv/angle_bias_kalman_filter_core.sv
sv/abkf_checker.sv
verif/testbench.sv
